FILE: rtl/rpd_pkg.sv
package rpd_pkg;

    localparam int RENORM_PERIOD = 64;
    localparam int CNT_W = $clog2(RENORM_PERIOD);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RENORM_PERIOD - 1);

    localparam logic [1:0] CMD_ROTATE  = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_RESET   = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;   // unused code, changes nothing

    localparam logic REG_STEP_SIN = 1'b0;
    localparam logic REG_STEP_COS = 1'b1;

    localparam logic signed [19:0] Q14_ONE = 20'sd16384;
    localparam logic signed [19:0] ACC_MAX = 20'sd524287;
    localparam logic signed [19:0] ACC_MIN = -20'sd524288;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;    // capture input transfer
        logic rotate;     // compute rotated sample from current phasor
        logic mul_c;      // phasor step, cosine product pair
        logic mul_s;      // phasor step, sine product pair and update
        logic sqrt_init;  // load magnitude squared into root unit
        logic sqrt_step;  // one root iteration
        logic div_init;   // start divisions
        logic div_step;   // one quotient bit
        logic div_done;   // write back normalized phasor
        logic reset_ph;   // phasor to (1,0)
        logic load_out;   // publish result
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       cnt_zero;   // remaining advance count is zero
        logic       renorm_due; // period counter wrapped on last phasor step
        logic       mag_zero;
        logic       sqrt_last;
        logic       root_zero;
        logic       div_last;
    } sts_t;

    function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
        if (v > 48'(ACC_MAX)) return ACC_MAX;
        if (v < 48'(ACC_MIN)) return ACC_MIN;
        return v[19:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sh7FFF;
        if (v < -48'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

FILE: rtl/rpd_datapath.sv
module rpd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [1:0]           s_cmd,
    input  logic signed [15:0]   s_sample_i,
    input  logic signed [15:0]   s_sample_q,
    input  logic [15:0]          s_chip_count,
    input  rpd_pkg::ctl_t        ctl,
    output rpd_pkg::sts_t        sts,
    output logic signed [15:0]   m_rot_i,
    output logic signed [15:0]   m_rot_q,
    output logic signed [19:0]   m_phasor_cos,
    output logic signed [19:0]   m_phasor_sin
);

    logic signed [15:0] step_sin_reg, step_cos_reg;
    logic signed [19:0] acc_cos_reg, acc_sin_reg;
    logic [rpd_pkg::CNT_W-1:0] phase_cnt_reg;
    logic renorm_reg;
    logic [1:0]  cmd_reg;
    logic signed [15:0] xi_reg, xq_reg;
    logic [15:0] remain_reg;
    logic signed [15:0] ri_reg, rq_reg;
    logic signed [35:0] p0_reg, p1_reg;
    // root unit
    logic [41:0] rem_reg;
    logic [21:0] root_reg;
    logic [4:0]  sq_it_reg;
    // dual restoring divider on magnitudes
    logic [34:0] dnc_reg, dns_reg;   // dividend/quotient shift registers
    logic [21:0] drc_reg, drs_reg;   // partial remainders
    logic [5:0]  dv_it_reg;
    logic        negc_reg, negs_reg;

    // Shared multiplier pair, operands chosen per phase
    logic signed [19:0] ma0, ma1;
    logic signed [15:0] mb0, mb1;
    logic signed [35:0] pr0, pr1;
    always_comb begin
        ma0 = acc_cos_reg; ma1 = acc_sin_reg;
        mb0 = step_cos_reg; mb1 = step_sin_reg;
        if (ctl.rotate) begin
            mb0 = xi_reg; mb1 = xq_reg;
        end else if (ctl.mul_s) begin
            mb0 = step_sin_reg; mb1 = step_cos_reg;
        end
        pr0 = ma0 * mb0;
        pr1 = ma1 * mb1;
    end

    logic signed [47:0] sum_c, sum_s, rsum_i, rsum_q;
    assign sum_c  = (48'(p0_reg) - 48'(p1_reg)) >>> 14;
    assign sum_s  = (48'(pr0) + 48'(pr1)) >>> 14;
    // rotation: ri = c*xi + s*xq on the shared pair; rq = xq*c - xi*s on its own pair
    assign rsum_i = (48'(pr0) + 48'(pr1)) >>> 14;

    logic signed [35:0] rq_a, rq_b;
    assign rq_a = acc_cos_reg * xq_reg;
    assign rq_b = acc_sin_reg * xi_reg;
    assign rsum_q = (48'(rq_a) - 48'(rq_b)) >>> 14;

    // magnitudes for renorm
    logic [19:0] absc, abss;
    logic [39:0] sq_c, sq_s;
    logic [41:0] mag2;
    assign absc = acc_cos_reg[19] ? 20'(-acc_cos_reg) : acc_cos_reg;
    assign abss = acc_sin_reg[19] ? 20'(-acc_sin_reg) : acc_sin_reg;
    assign sq_c = absc * absc;
    assign sq_s = abss * abss;
    assign mag2 = 42'(sq_c) + 42'(sq_s);

    // root step: two bits of radicand per iteration
    logic [43:0] trial;
    assign trial = {rem_reg, sq_src_reg[41:40]} - 44'({root_reg, 2'b01});

    // signed numerators x*16384 + sm/2, split into sign and magnitude
    logic signed [35:0] numc, nums;
    logic [34:0] magc, mags;
    assign numc = (36'(acc_cos_reg) <<< 14) + 36'(root_reg[21:1]);
    assign nums = (36'(acc_sin_reg) <<< 14) + 36'(root_reg[21:1]);
    assign magc = numc[35] ? 35'(-numc) : numc[34:0];
    assign mags = nums[35] ? 35'(-nums) : nums[34:0];

    // divide step
    logic [22:0] tc, ts;
    assign tc = {drc_reg, dnc_reg[34]} - 23'(root_reg);
    assign ts = {drs_reg, dns_reg[34]} - 23'(root_reg);

    logic signed [47:0] qc, qs;
    assign qc = negc_reg ? -48'(dnc_reg) : 48'(dnc_reg);
    assign qs = negs_reg ? -48'(dns_reg) : 48'(dns_reg);

    logic [41:0] sq_src_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_sin_reg  <= '0;
            step_cos_reg  <= 16'sd16384;
            acc_cos_reg   <= rpd_pkg::Q14_ONE;
            acc_sin_reg   <= '0;
            phase_cnt_reg <= '0;
            renorm_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == rpd_pkg::REG_STEP_SIN) step_sin_reg <= cfg_data;
                else                                    step_cos_reg <= cfg_data;
                acc_cos_reg   <= rpd_pkg::Q14_ONE;
                acc_sin_reg   <= '0;
                phase_cnt_reg <= '0;
            end
            if (ctl.reset_ph) begin
                acc_cos_reg   <= rpd_pkg::Q14_ONE;
                acc_sin_reg   <= '0;
                phase_cnt_reg <= '0;
            end
            if (ctl.mul_s) begin
                acc_cos_reg   <= rpd_pkg::sat20(sum_c);
                acc_sin_reg   <= rpd_pkg::sat20(sum_s);
                renorm_reg    <= (phase_cnt_reg == rpd_pkg::CNT_LAST);
                phase_cnt_reg <= (phase_cnt_reg == rpd_pkg::CNT_LAST) ? '0
                                 : phase_cnt_reg + 1'b1;
            end
            if (ctl.div_done) begin
                acc_cos_reg <= rpd_pkg::sat20(qc);
                acc_sin_reg <= rpd_pkg::sat20(qs);
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg    <= s_cmd;
            xi_reg     <= s_sample_i;
            xq_reg     <= s_sample_q;
            remain_reg <= s_chip_count;
            ri_reg     <= '0;
            rq_reg     <= '0;
        end
        if (ctl.rotate) begin
            ri_reg <= rpd_pkg::sat16(rsum_i);
            rq_reg <= rpd_pkg::sat16(rsum_q);
        end
        if (ctl.mul_c) begin
            p0_reg <= pr0;
            p1_reg <= acc_sin_reg * step_sin_reg;
        end
        if (ctl.mul_s && cmd_reg == rpd_pkg::CMD_ADVANCE)
            remain_reg <= remain_reg - 1'b1;
        // magnitude squared into the root unit
        if (ctl.sqrt_init) begin
            sq_src_reg <= mag2;
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_it_reg  <= '0;
        end
        if (ctl.sqrt_step) begin
            if (!trial[43]) begin
                rem_reg  <= trial[41:0];
                root_reg <= {root_reg[20:0], 1'b1};
            end else begin
                rem_reg  <= {rem_reg[39:0], sq_src_reg[41:40]};
                root_reg <= {root_reg[20:0], 1'b0};
            end
            sq_src_reg <= {sq_src_reg[39:0], 2'b00};
            sq_it_reg  <= sq_it_reg + 1'b1;
        end
        if (ctl.div_init) begin
            negc_reg <= numc[35];
            negs_reg <= nums[35];
            dnc_reg  <= magc;
            dns_reg  <= mags;
            drc_reg  <= '0;
            drs_reg  <= '0;
            dv_it_reg <= '0;
        end
        if (ctl.div_step) begin
            if (!tc[22]) begin
                drc_reg <= tc[21:0]; dnc_reg <= {dnc_reg[33:0], 1'b1};
            end else begin
                drc_reg <= {drc_reg[20:0], dnc_reg[34]}; dnc_reg <= {dnc_reg[33:0], 1'b0};
            end
            if (!ts[22]) begin
                drs_reg <= ts[21:0]; dns_reg <= {dns_reg[33:0], 1'b1};
            end else begin
                drs_reg <= {drs_reg[20:0], dns_reg[34]}; dns_reg <= {dns_reg[33:0], 1'b0};
            end
            dv_it_reg <= dv_it_reg + 1'b1;
        end
        if (ctl.load_out) begin
            m_rot_i      <= ri_reg;
            m_rot_q      <= rq_reg;
            m_phasor_cos <= acc_cos_reg;
            m_phasor_sin <= acc_sin_reg;
        end
    end

    assign sts.cmd        = cmd_reg;
    assign sts.cnt_zero   = (remain_reg == '0);
    assign sts.renorm_due = renorm_reg;
    assign sts.mag_zero   = (sq_src_reg == '0) && (sq_it_reg == '0);
    assign sts.sqrt_last  = (sq_it_reg == 5'd21);
    assign sts.root_zero  = (root_reg == '0);
    assign sts.div_last   = (dv_it_reg == 6'd35);

endmodule

FILE: rtl/rpd_ctrl.sv
module rpd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rpd_pkg::sts_t sts,
    output rpd_pkg::ctl_t ctl
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC  = 4'd1;
    localparam logic [3:0] ST_MC   = 4'd2;
    localparam logic [3:0] ST_MS   = 4'd3;
    localparam logic [3:0] ST_SQ0  = 4'd4;
    localparam logic [3:0] ST_SQ1  = 4'd5;
    localparam logic [3:0] ST_SQ   = 4'd6;
    localparam logic [3:0] ST_DI   = 4'd7;
    localparam logic [3:0] ST_DV   = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;
    localparam logic [3:0] ST_CHK  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       sq_phase;

    // next item may be taken while a finished result waits in the output register
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign sq_phase = (state_reg == ST_SQ0);

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        ctl        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    ctl.load_in = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                if (sts.cmd == rpd_pkg::CMD_ROTATE) begin
                    ctl.rotate = 1'b1;
                    state_next = ST_MC;
                end else if (sts.cmd == rpd_pkg::CMD_ADVANCE) begin
                    state_next = ST_CHK;
                end else begin
                    ctl.reset_ph = (sts.cmd == rpd_pkg::CMD_RESET);
                    state_next   = ST_OUT;
                end
            end
            ST_CHK: state_next = sts.cnt_zero ? ST_OUT : ST_MC;
            ST_MC: begin
                ctl.mul_c  = 1'b1;
                state_next = ST_MS;
            end
            ST_MS: begin
                ctl.mul_s  = 1'b1;
                state_next = ST_SQ1;
            end
            ST_SQ1: begin
                // renorm check after counter update
                if (sts.renorm_due) state_next = ST_SQ0;
                else if (sts.cmd == rpd_pkg::CMD_ADVANCE) state_next = ST_CHK;
                else state_next = ST_OUT;
            end
            ST_SQ0: begin
                ctl.mul_c     = 1'b0;
                ctl.sqrt_init = 1'b1;
                state_next    = ST_SQ;
            end
            ST_SQ: begin
                if (sts.sqrt_last) begin
                    state_next = sts.root_zero ? ST_SQ1 : ST_DI;
                    if (sts.root_zero)
                        state_next = (sts.cmd == rpd_pkg::CMD_ADVANCE) ? ST_CHK : ST_OUT;
                end else begin
                    ctl.sqrt_step = 1'b1;
                end
            end
            ST_DI: begin
                ctl.div_init = 1'b1;
                state_next   = ST_DV;
            end
            ST_DV: begin
                if (sts.div_last) begin
                    ctl.div_done = 1'b1;
                    state_next = (sts.cmd == rpd_pkg::CMD_ADVANCE) ? ST_CHK : ST_OUT;
                end else begin
                    ctl.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    ctl.load_out = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (sq_phase) ctl.mul_c = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    a_one_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |-> state_reg == ST_OUT) else $error("output load outside OUT");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |=> mv_reg) else $error("result lost");

endmodule

FILE: rtl/recursive_phasor_derotator.sv
// Recursive phasor derotator: rotates complex chips by a Q14 phasor that steps
// by the configured per-chip rotation. One item at a time: a rotate result is
// loaded once the rotation and the phasor step are done, and the next input is
// taken after that; an advance of N chips steps the phasor N times, and a reset
// or the unused command goes straight to the output. The chip that completes
// each 64-chip period adds the bit-serial square root (21 iterations) and the
// two bit-serial dividers running side by side (35 iterations). The result sits
// in an output register so the next item can be taken while it waits.
module recursive_phasor_derotator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic signed [15:0]  s_sample_i,
    input  logic signed [15:0]  s_sample_q,
    input  logic [15:0]         s_chip_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_rot_i,
    output logic signed [15:0]  m_rot_q,
    output logic signed [19:0]  m_phasor_cos,
    output logic signed [19:0]  m_phasor_sin
);

    rpd_pkg::ctl_t ctl;
    rpd_pkg::sts_t sts;

    rpd_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .ctl
    );

    rpd_datapath u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_cmd, .s_sample_i, .s_sample_q, .s_chip_count,
        .ctl, .sts, .m_rot_i, .m_rot_q, .m_phasor_cos, .m_phasor_sin
    );

endmodule

FILE: bench/rpd_checker.sv
module rpd_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic signed [15:0]  s_sample_i,
    input  logic signed [15:0]  s_sample_q,
    input  logic [15:0]         s_chip_count,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic signed [15:0]  m_rot_i,
    input  logic signed [15:0]  m_rot_q,
    input  logic signed [19:0]  m_phasor_cos,
    input  logic signed [19:0]  m_phasor_sin,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] rot_i;
        logic signed [15:0] rot_q;
        logic signed [19:0] ph_cos;
        logic signed [19:0] ph_sin;
    } chip_result_t;

    chip_result_t derot_expected[$];

    // Shadow of the block's registers and phasor
    logic signed [15:0] step_sin_q;
    logic signed [15:0] step_cos_q;
    logic signed [19:0] ph_cos_q;
    logic signed [19:0] ph_sin_q;
    int unsigned        period_cnt;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 42;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void restart_phasor();
        ph_cos_q   = rpd_pkg::Q14_ONE;
        ph_sin_q   = 20'sd0;
        period_cnt = 0;
    endfunction

    // One chip of phasor rotation, renormalizing at the end of each period
    function automatic void step_phasor();
        longint c;
        longint s;
        longint sm;
        c = ph_cos_q;
        s = ph_sin_q;
        ph_cos_q = 20'(clamp((c * step_cos_q - s * step_sin_q) >>> 14,
                             rpd_pkg::ACC_MIN, rpd_pkg::ACC_MAX));
        ph_sin_q = 20'(clamp((c * step_sin_q + s * step_cos_q) >>> 14,
                             rpd_pkg::ACC_MIN, rpd_pkg::ACC_MAX));
        period_cnt++;
        if (period_cnt >= rpd_pkg::RENORM_PERIOD) begin
            period_cnt = 0;
            c = ph_cos_q;
            s = ph_sin_q;
            sm = longint'(floor_root(c * c + s * s));
            if (sm != 0) begin
                ph_cos_q = 20'(clamp((c * 16384 + sm / 2) / sm,
                                     rpd_pkg::ACC_MIN, rpd_pkg::ACC_MAX));
                ph_sin_q = 20'(clamp((s * 16384 + sm / 2) / sm,
                                     rpd_pkg::ACC_MIN, rpd_pkg::ACC_MAX));
            end
        end
    endfunction

    function automatic chip_result_t derotate(input logic [1:0] cmd,
                                              input logic signed [15:0] xi,
                                              input logic signed [15:0] xq,
                                              input logic [15:0] nchips);
        chip_result_t r;
        longint c;
        longint s;
        r = '0;
        c = ph_cos_q;
        s = ph_sin_q;
        case (cmd)
            rpd_pkg::CMD_ROTATE: begin
                r.rot_i = 16'(clamp((xi * c + xq * s) >>> 14, -32768, 32767));
                r.rot_q = 16'(clamp((xq * c - xi * s) >>> 14, -32768, 32767));
                step_phasor();
            end
            rpd_pkg::CMD_ADVANCE: begin
                for (int k = 0; k < nchips; k++) step_phasor();
            end
            rpd_pkg::CMD_RESET: restart_phasor();
            default: ;
        endcase
        r.ph_cos = ph_cos_q;
        r.ph_sin = ph_sin_q;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending = derot_expected.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        chip_result_t w;
        if (!aresetn) begin
            step_sin_q = 16'sd0;
            step_cos_q = 16'sd16384;
            restart_phasor();
            derot_expected.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == rpd_pkg::REG_STEP_SIN) step_sin_q = cfg_data;
                else step_cos_q = cfg_data;
                restart_phasor();
            end
            if (s_valid && s_ready)
                derot_expected.push_back(derotate(s_cmd, s_sample_i, s_sample_q,
                                                  s_chip_count));
            // result transfer against oldest prediction
            if (m_valid && m_ready) begin
                if (derot_expected.size() == 0) begin
                    report("unexpected result, rot_i", m_rot_i, 0);
                end else begin
                    w = derot_expected.pop_front();
                    if (m_rot_i !== w.rot_i) report("rot_i", m_rot_i, w.rot_i);
                    if (m_rot_q !== w.rot_q) report("rot_q", m_rot_q, w.rot_q);
                    if (m_phasor_cos !== w.ph_cos)
                        report("phasor_cos", m_phasor_cos, w.ph_cos);
                    if (m_phasor_sin !== w.ph_sin)
                        report("phasor_sin", m_phasor_sin, w.ph_sin);
                end
            end
        end
    end
endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = rpd_pkg::REG_STEP_SIN;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = rpd_pkg::CMD_ROTATE;
    logic signed [15:0] s_sample_i = '0;
    logic signed [15:0] s_sample_q = '0;
    logic [15:0]        s_chip_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_rot_i;
    logic signed [15:0] m_rot_q;
    logic signed [19:0] m_phasor_cos;
    logic signed [19:0] m_phasor_sin;
    int                 fail_count;
    int                 pending;
    logic               long_hold = 1'b0;

    always #6 aclk = ~aclk;

    recursive_phasor_derotator dut (.*);

    rpd_checker chk (.*);

    // Offer one item and hold it until the transfer happens
    task automatic send_chip(input logic [1:0] cmd, input logic [15:0] xi,
                             input logic [15:0] xq, input logic [15:0] n);
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_sample_i   <= xi;
        s_sample_q   <= xq;
        s_chip_count <= n;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_step(input logic sel, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_burst(input int count);
        int left;
        int burst;
        int pick;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_chip(rpd_pkg::CMD_ROTATE, rand_sample(), rand_sample(),
                              16'($urandom));
                else if (pick < 85)
                    send_chip(rpd_pkg::CMD_ADVANCE, 16'($urandom), 16'($urandom),
                              16'($urandom_range(0, 130)));
                else if (pick < 93)
                    send_chip(rpd_pkg::CMD_RESET, 16'($urandom), 16'($urandom),
                              16'($urandom));
                else
                    send_chip(rpd_pkg::CMD_SPARE, 16'($urandom), 16'($urandom),
                              16'($urandom));
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
        end
    endtask

    // Receiver: randomly chosen stall patterns, plus a long hold-off on request
    initial begin
        int mode;
        int span;
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 80);
            repeat (span) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int wait_cnt;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of samples, every command, long advance
        write_step(rpd_pkg::REG_STEP_SIN, 16'sd6393);
        write_step(rpd_pkg::REG_STEP_COS, 16'sd15081);
        send_chip(rpd_pkg::CMD_ROTATE, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_chip(rpd_pkg::CMD_ROTATE, 16'h8000, 16'h8000, 16'hFFFF);
        send_chip(rpd_pkg::CMD_ROTATE, 16'h8000, 16'h7FFF, 16'h0000);
        send_chip(rpd_pkg::CMD_ROTATE, 16'h0000, 16'h0000, 16'h0000);
        send_chip(rpd_pkg::CMD_ROTATE, 16'hFFFF, 16'h0001, 16'h0000);
        send_chip(rpd_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 16'd0);
        send_chip(rpd_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 16'd57);
        send_chip(rpd_pkg::CMD_ROTATE, 16'h1234, 16'hEDCB, 16'h0000);
        send_chip(rpd_pkg::CMD_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_chip(rpd_pkg::CMD_SPARE, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_chip(rpd_pkg::CMD_RESET, 16'h0000, 16'h0000, 16'h0000);
        send_chip(rpd_pkg::CMD_ADVANCE, 16'h0000, 16'h0000, 16'd64);
        send_chip(rpd_pkg::CMD_ROTATE, 16'h7FFF, 16'h8000, 16'h0000);
        drain();

        // Step settings: nominal, extremes, out of range, zero magnitude
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_step(rpd_pkg::REG_STEP_SIN, 16'sd0);
                         write_step(rpd_pkg::REG_STEP_COS, 16'sd16384); end
                1: begin write_step(rpd_pkg::REG_STEP_SIN, 16'sd16384);
                         write_step(rpd_pkg::REG_STEP_COS, -16'sd16384); end
                2: begin write_step(rpd_pkg::REG_STEP_SIN, -16'sd16384);
                         write_step(rpd_pkg::REG_STEP_COS, 16'sd16384); end
                3: begin write_step(rpd_pkg::REG_STEP_SIN, 16'h7FFF);
                         write_step(rpd_pkg::REG_STEP_COS, 16'h8000); end
                4: begin write_step(rpd_pkg::REG_STEP_SIN, 16'sd0);
                         write_step(rpd_pkg::REG_STEP_COS, 16'sd0); end
                default: begin
                    write_step(rpd_pkg::REG_STEP_SIN, 16'($urandom_range(0, 4000)));
                    write_step(rpd_pkg::REG_STEP_COS, 16'sd16300);
                end
            endcase
            random_burst(80);
            if (ph == 1) begin
                // stall the output long enough to back up the input
                long_hold = 1'b1;
                repeat (30) send_chip(rpd_pkg::CMD_ROTATE, rand_sample(), rand_sample(),
                                      16'h0);
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            random_burst(75);
            drain();
        end

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
